@@ rtl/core/dendrogram_merge_builder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DENDROGRAM_MERGE_BUILDER_TOP_DEFINES_SVH
`define DENDROGRAM_MERGE_BUILDER_TOP_DEFINES_SVH

// same-cycle implication
`define DMB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dmb_pkg.sv @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder package
// Sizes, store request and result types shared by the block's modules.
// ----------------------------------------------------------------------------
package dmb_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int PT_W        = 11;
    localparam int SIDE_W      = 11;
    localparam int SIDE_X_W    = SIDE_W + 1;
    localparam int CN_W        = 10;
    localparam int RAM_DEPTH   = 1024;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int STEP_W      = $clog2(MAX_POINTS + 1);
    localparam int CLUSTER_TOP = ((MAX_POINTS - 1) < 1023) ? (MAX_POINTS - 1) : 1023;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CN_W-1:0]   wdata;
        logic [ADDR_W-1:0] raddr;
    } dmb_ram_req_t;

    typedef struct packed {
        logic                valid;
        logic [SIDE_X_W-1:0] side_a;
        logic [SIDE_X_W-1:0] side_b;
        logic [CN_W-1:0]     cn;
        logic                last;
    } dmb_result_t;

endpackage

@@ rtl/core/dmb_ram.sv @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder store
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module dmb_ram
    import dmb_pkg::*;
(
    input  logic            clk,
    input  dmb_ram_req_t    req,
    output logic [CN_W-1:0] rdata
);

    logic [CN_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

@@ rtl/core/dmb_seq.sv @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder sequencer
// Clears the stores, reads and rewrites owners, walks the parent chain of each owned side.
// ----------------------------------------------------------------------------
module dmb_seq
    import dmb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PT_W-1:0]   point_a,
    input  logic [PT_W-1:0]   point_b,
    input  logic              last_link,
    output dmb_ram_req_t      own_req,
    input  logic [CN_W-1:0]   own_q,
    output dmb_ram_req_t      par_req,
    input  logic [CN_W-1:0]   par_q,
    output dmb_result_t       res,
    input  logic              res_ready
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RDB    = 8'b0000_0100,
        ST_WRA    = 8'b0000_1000,
        ST_WRB    = 8'b0001_0000,
        ST_WALK_A = 8'b0010_0000,
        ST_WALK_B = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } dmb_state_t;

    dmb_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [CN_W-1:0]     cn_reg, cn_next;
    logic [PT_W-1:0]     pa_reg, pa_next;
    logic [PT_W-1:0]     pb_reg, pb_next;
    logic                last_reg, last_next;
    logic [CN_W-1:0]     oa_reg, oa_next;
    logic [CN_W-1:0]     ob_reg, ob_next;
    logic [CN_W-1:0]     s_reg, s_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [SIDE_X_W-1:0] side_a_reg, side_a_next;
    logic [SIDE_X_W-1:0] side_b_reg, side_b_next;
    logic                fwd_hit_reg;
    logic [CN_W-1:0]     fwd_data_reg;
    logic [CN_W-1:0]     par_rd;
    logic                a_in_range;
    logic                b_in_range;
    logic                in_range_new;
    logic                walk_more;

    assign a_in_range   = (pa_reg != '0) && (pa_reg <= PT_W'(MAX_POINTS));
    assign b_in_range   = (pb_reg != '0) && (pb_reg <= PT_W'(MAX_POINTS));
    assign in_range_new = (point_a != '0) && (point_a <= PT_W'(MAX_POINTS));
    assign par_rd       = fwd_hit_reg ? fwd_data_reg : par_q;
    assign walk_more    = (par_rd != '0) && (steps_reg < STEP_W'(MAX_POINTS));
    assign in_stall     = (state_reg != ST_IDLE);

    always_comb
    begin
        res.valid  = (state_reg == ST_DONE);
        res.side_a = side_a_reg;
        res.side_b = side_b_reg;
        res.cn     = cn_reg;
        res.last   = last_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cn_next     = cn_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        last_next   = last_reg;
        oa_next     = oa_reg;
        ob_next     = ob_reg;
        s_next      = s_reg;
        steps_next  = steps_reg;
        side_a_next = side_a_reg;
        side_b_next = side_b_reg;
        own_req     = '0;
        par_req     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                own_req.we    = 1'b1;
                own_req.waddr = clr_reg;
                par_req.we    = 1'b1;
                par_req.waddr = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(RAM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                own_req.raddr = ADDR_W'(point_a - 1'b1);
                if (in_valid)
                begin
                    pa_next    = point_a;
                    pb_next    = point_b;
                    last_next  = last_link;
                    state_next = ST_RDB;
                end
            end
            ST_RDB:
            begin
                own_req.raddr = ADDR_W'(pb_reg - 1'b1);
                oa_next       = a_in_range ? own_q : '0;
                state_next    = ST_WRA;
            end
            ST_WRA:
            begin
                ob_next       = b_in_range ? own_q : '0;
                own_req.we    = a_in_range;
                own_req.waddr = ADDR_W'(pa_reg - 1'b1);
                own_req.wdata = cn_reg;
                state_next    = ST_WRB;
            end
            ST_WRB:
            begin
                own_req.we    = b_in_range;
                own_req.waddr = ADDR_W'(pb_reg - 1'b1);
                own_req.wdata = cn_reg;
                side_a_next   = (~{1'b0, pa_reg}) + 1'b1;
                side_b_next   = (~{1'b0, pb_reg}) + 1'b1;
                steps_next    = '0;
                priority if (oa_reg != '0)
                begin
                    par_req.raddr = oa_reg;
                    s_next        = oa_reg;
                    state_next    = ST_WALK_A;
                end
                else if (ob_reg != '0)
                begin
                    par_req.raddr = ob_reg;
                    s_next        = ob_reg;
                    state_next    = ST_WALK_B;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK_A:
            begin
                par_req.we    = 1'b1;
                par_req.waddr = s_reg;
                par_req.wdata = cn_reg;
                priority if (walk_more)
                begin
                    par_req.raddr = par_rd;
                    s_next        = par_rd;
                    steps_next    = steps_reg + 1'b1;
                end
                else if (ob_reg != '0)
                begin
                    side_a_next   = {2'b00, s_reg};
                    par_req.raddr = ob_reg;
                    s_next        = ob_reg;
                    steps_next    = '0;
                    state_next    = ST_WALK_B;
                end
                else
                begin
                    side_a_next = {2'b00, s_reg};
                    state_next  = ST_DONE;
                end
            end
            ST_WALK_B:
            begin
                par_req.we    = 1'b1;
                par_req.waddr = s_reg;
                par_req.wdata = cn_reg;
                if (walk_more)
                begin
                    par_req.raddr = par_rd;
                    s_next        = par_rd;
                    steps_next    = steps_reg + 1'b1;
                end
                else
                begin
                    side_b_next = {2'b00, s_reg};
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    if (cn_reg < CN_W'(CLUSTER_TOP))
                    begin
                        cn_next = cn_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the owner read address quiet when the new point has no entry
        if ((state_reg == ST_IDLE) && !in_range_new)
        begin
            own_req.raddr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cn_reg    <= CN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cn_reg    <= cn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        last_reg     <= last_next;
        oa_reg       <= oa_next;
        ob_reg       <= ob_next;
        s_reg        <= s_next;
        steps_reg    <= steps_next;
        side_a_reg   <= side_a_next;
        side_b_reg   <= side_b_next;
        fwd_hit_reg  <= par_req.we && (par_req.waddr == par_req.raddr);
        fwd_data_reg <= par_req.wdata;
    end

endmodule

@@ rtl/core/dendrogram_merge_builder_top.sv @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder
// Turns links of two point indices into ordered rows of a merge matrix.
//
//   channel   signals                                     direction
//   in        in_valid, in_stall, point_a/b, last_link    request in
//   out       out_valid, out_stall, merge_first/second,   request out
//             new_cluster, done_res
//
// An item reads both owners, writes the new cluster as owner of both points,
// then follows the parent links on each side that has an owner, rewriting
// each visited parent to the new cluster. The parent store reads one entry
// per cycle. After reset a clearing pass zeroes both stores; in_stall
// stays high meanwhile. A stalled result waits in the output register while
// the next request is already taken in.
// ----------------------------------------------------------------------------
module dendrogram_merge_builder_top
    import dmb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PT_W-1:0]          point_a,
    input  logic [PT_W-1:0]          point_b,
    input  logic                     last_link,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SIDE_W-1:0] merge_first,
    output logic signed [SIDE_W-1:0] merge_second,
    output logic [CN_W-1:0]          new_cluster,
    output logic                     done_res
);

    dmb_ram_req_t               own_req;
    dmb_ram_req_t               par_req;
    logic [CN_W-1:0]            own_q;
    logic [CN_W-1:0]            par_q;
    dmb_result_t                res;
    logic                       res_ready;
    logic                       out_valid_reg;
    logic signed [SIDE_W-1:0]   first_reg;
    logic signed [SIDE_W-1:0]   second_reg;
    logic [CN_W-1:0]            cn_reg;
    logic                       done_reg;
    logic signed [SIDE_X_W-1:0] fa;
    logic signed [SIDE_X_W-1:0] fb;
    logic                       swap;

    dmb_ram u_owner_ram (
        .clk   (clk),
        .req   (own_req),
        .rdata (own_q)
    );

    dmb_ram u_parent_ram (
        .clk   (clk),
        .req   (par_req),
        .rdata (par_q)
    );

    dmb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_a   (point_a),
        .point_b   (point_b),
        .last_link (last_link),
        .own_req   (own_req),
        .own_q     (own_q),
        .par_req   (par_req),
        .par_q     (par_q),
        .res       (res),
        .res_ready (res_ready)
    );

    assign fa        = $signed(res.side_a);
    assign fb        = $signed(res.side_b);
    assign res_ready = !out_valid_reg || !out_stall;

    // singletons before clusters, larger negative index last
    always_comb
    begin
        if (fa < 0)
        begin
            swap = (fb < 0) && (fa < fb);
        end
        else
        begin
            swap = (fa > fb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            first_reg  <= swap ? fb[SIDE_W-1:0] : fa[SIDE_W-1:0];
            second_reg <= swap ? fa[SIDE_W-1:0] : fb[SIDE_W-1:0];
            cn_reg     <= res.cn;
            done_reg   <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merge_first  = first_reg;
    assign merge_second = second_reg;
    assign new_cluster  = cn_reg;
    assign done_res     = done_reg;

endmodule

@@ rtl/core/dmb_checker.sv @@
// ----------------------------------------------------------------------------
// Dendrogram merge builder port checker
// Watches the top level's ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "dendrogram_merge_builder_top_defines.svh"

module dmb_checker
    import dmb_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [SIDE_W-1:0] merge_first,
    input logic signed [SIDE_W-1:0] merge_second,
    input logic [CN_W-1:0]          new_cluster
);

    `DMB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(merge_first) && $stable(merge_second) && $stable(new_cluster), "stalled result changed")
    `DMB_ASSERT_NOW(a_out_known, out_valid, !$isunknown({merge_first, merge_second, new_cluster}), "unknown bits in result")
    `DMB_ASSERT_NOW(a_single_order, out_valid && (merge_second < 0), (merge_first < 0) && (merge_first >= merge_second), "singleton sides out of order")
    `DMB_ASSERT_NOW(a_cluster_nonzero, out_valid, new_cluster != '0, "zero cluster number")
    `DMB_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second request taken during walk")

endmodule

bind dendrogram_merge_builder_top dmb_checker u_dmb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merge_first  (merge_first),
    .merge_second (merge_second),
    .new_cluster  (new_cluster)
);
